// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [1:0] {
      CMD_MUL = 2'd0,
      CMD_DIV = 2'd1,
      CMD_ADD = 2'd2,
      CMD_SUB = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_DBZ = 2'd1,
      ST_OVF = 2'd2
   } status_type;

   // per-word control decided in the front end
   typedef struct packed {
      cmd_type cmd;
      logic    dbz;
   } ctrl_type;

endpackage

// ===== hw/rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Command register: takes a word, decodes it and hands it to the queue.
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [DATA_WIDTH-1:0] req_a_real,
   input  logic [DATA_WIDTH-1:0] req_a_imag,
   input  logic [DATA_WIDTH-1:0] req_b_real,
   input  logic [DATA_WIDTH-1:0] req_b_imag,
   input  logic                  q_full,
   output logic                  push,
   output cau_pkg::ctrl_type     fe_ctrl,
   output logic [DATA_WIDTH-1:0] fe_a_real,
   output logic [DATA_WIDTH-1:0] fe_a_imag,
   output logic [DATA_WIDTH-1:0] fe_b_real,
   output logic [DATA_WIDTH-1:0] fe_b_imag
);

   logic              valid_ff, valid_in;
   logic              accept;
   cau_pkg::ctrl_type ctrl_ff;
   logic [DATA_WIDTH-1:0] a_real_ff, a_imag_ff, b_real_ff, b_imag_ff;

   always_comb begin
      push     = valid_ff & ~q_full;
      busy     = valid_ff & q_full;
      accept   = start & ~busy;
      valid_in = accept | (valid_ff & ~push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff.cmd <= cau_pkg::cmd_type'(req_cmd);
         ctrl_ff.dbz <= (req_b_real == '0) && (req_b_imag == '0);
         a_real_ff   <= req_a_real;
         a_imag_ff   <= req_a_imag;
         b_real_ff   <= req_b_real;
         b_imag_ff   <= req_b_imag;
      end
   end

   assign fe_ctrl   = ctrl_ff;
   assign fe_a_real = a_real_ff;
   assign fe_a_imag = a_imag_ff;
   assign fe_b_real = b_real_ff;
   assign fe_b_imag = b_imag_ff;

endmodule

// ===== hw/rtl/cau_queue.sv =====
// ----------------------------------------------------------------------------
// cau_queue
// Two-entry word queue between the front end and the datapath.
// ----------------------------------------------------------------------------
module cau_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] entry_ff [0:1];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      do_pop    = pop & ~empty;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
      head      = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Datapath: products, sums, magnitudes, pipelined restoring divider, saturation.
// ----------------------------------------------------------------------------
module cau_back #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cau_pkg::ctrl_type     in_ctrl,
   input  logic [DATA_WIDTH-1:0] in_a_real,
   input  logic [DATA_WIDTH-1:0] in_a_imag,
   input  logic [DATA_WIDTH-1:0] in_b_real,
   input  logic [DATA_WIDTH-1:0] in_b_imag,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_result_real,
   output logic [DATA_WIDTH-1:0] rsp_result_imag,
   output logic [1:0]            rsp_status
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int SW = W + 1;
   localparam int PW = 2 * W;
   localparam int VW = PW + 1;
   localparam int NW = PW + F;
   localparam int TW = NW - W;
   localparam int CW = (TW > PW) ? TW : PW;
   localparam logic [PW-1:0] LIM  = PW'(1) << (W - 1);
   localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  MAXV = ~MINV;

   // stage a: products and sums
   logic              a_valid_ff;
   cau_pkg::ctrl_type a_ctrl_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_br_ff, p_bi_ff;
   logic signed [SW-1:0] s_re_ff, s_im_ff, s_re_in, s_im_in;
   logic signed [W-1:0]  ar, ai, br, bi;

   always_comb begin
      ar = in_a_real;
      ai = in_a_imag;
      br = in_b_real;
      bi = in_b_imag;
      if (in_ctrl.cmd == cau_pkg::CMD_SUB) begin
         s_re_in = SW'(ar) - SW'(br);
         s_im_in = SW'(ai) - SW'(bi);
      end else begin
         s_re_in = SW'(ar) + SW'(br);
         s_im_in = SW'(ai) + SW'(bi);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_ctrl_ff <= in_ctrl;
      p_rr_ff   <= PW'(ar) * PW'(br);
      p_ii_ff   <= PW'(ai) * PW'(bi);
      p_ri_ff   <= PW'(ar) * PW'(bi);
      p_ir_ff   <= PW'(ai) * PW'(br);
      p_br_ff   <= PW'(br) * PW'(br);
      p_bi_ff   <= PW'(bi) * PW'(bi);
      s_re_ff   <= s_re_in;
      s_im_ff   <= s_im_in;
   end

   // stage b: combine per command
   logic              b_valid_ff;
   cau_pkg::ctrl_type b_ctrl_ff;
   logic signed [VW-1:0] v_re_ff, v_im_ff, v_re_in, v_im_in;
   logic [PW-1:0]        b_den_ff;

   always_comb begin
      unique case (a_ctrl_ff.cmd)
         cau_pkg::CMD_MUL: begin
            v_re_in = VW'(p_rr_ff) - VW'(p_ii_ff);
            v_im_in = VW'(p_ri_ff) + VW'(p_ir_ff);
         end
         cau_pkg::CMD_DIV: begin
            v_re_in = VW'(p_rr_ff) + VW'(p_ii_ff);
            v_im_in = VW'(p_ir_ff) - VW'(p_ri_ff);
         end
         default: begin
            v_re_in = VW'(s_re_ff);
            v_im_in = VW'(s_im_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_ctrl_ff <= a_ctrl_ff;
      v_re_ff   <= v_re_in;
      v_im_ff   <= v_im_in;
      b_den_ff  <= $unsigned(p_br_ff) + $unsigned(p_bi_ff);
   end

   // stage c: sign and magnitude
   logic              c_valid_ff;
   cau_pkg::ctrl_type c_ctrl_ff;
   logic [1:0]        c_neg_ff;
   logic [PW-1:0]     c_mag_ff [0:1];
   logic [PW-1:0]     c_den_ff;
   logic [VW-1:0]     abs_re, abs_im;

   always_comb begin
      abs_re = v_re_ff[VW-1] ? VW'(-v_re_ff) : VW'(v_re_ff);
      abs_im = v_im_ff[VW-1] ? VW'(-v_im_ff) : VW'(v_im_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_ctrl_ff   <= b_ctrl_ff;
      c_neg_ff    <= {v_im_ff[VW-1], v_re_ff[VW-1]};
      c_mag_ff[0] <= abs_re[PW-1:0];
      c_mag_ff[1] <= abs_im[PW-1:0];
      c_den_ff    <= b_den_ff;
   end

   // divider rows: row 0 is set up from stage c, each later row adds one quotient bit
   logic              r_valid_ff [0:W];
   cau_pkg::ctrl_type r_ctrl_ff  [0:W];
   logic [PW-1:0]     r_den_ff   [0:W];
   logic [1:0]        r_neg_ff   [0:W];
   logic [1:0]        r_big_ff   [0:W];
   logic [PW-1:0]     r_mag_ff   [0:W][0:1];
   logic [PW-1:0]     r_rem_ff   [0:W][0:1];
   logic [W-1:0]      r_nlo_ff   [0:W][0:1];
   logic [W-1:0]      r_quo_ff   [0:W][0:1];

   logic [PW-1:0] init_mag [0:1];
   logic [PW-1:0] init_rem [0:1];
   logic [W-1:0]  init_nlo [0:1];
   logic [1:0]    init_big;
   logic [NW-1:0] nvec;
   logic [TW-1:0] top;

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         nvec        = NW'(c_mag_ff[p]) << F;
         top         = nvec[NW-1:W];
         init_big[p] = CW'(top) >= CW'(c_den_ff);
         init_rem[p] = init_big[p] ? '0 : PW'(top);
         init_nlo[p] = nvec[W-1:0];
         init_mag[p] = (c_ctrl_ff.cmd == cau_pkg::CMD_MUL) ? (c_mag_ff[p] >> F)
                                                           : c_mag_ff[p];
      end
   end

   logic [PW-1:0] step_rem [1:W][0:1];
   logic          step_bit [1:W][0:1];
   logic [PW:0]   shl      [1:W][0:1];
   logic [PW:0]   diff     [1:W][0:1];

   always_comb begin
      for (int k = 1; k <= W; k++) begin
         for (int p = 0; p < 2; p++) begin
            shl[k][p]      = {r_rem_ff[k-1][p], r_nlo_ff[k-1][p][W-1]};
            diff[k][p]     = shl[k][p] - {1'b0, r_den_ff[k-1]};
            step_bit[k][p] = ~diff[k][p][PW];
            step_rem[k][p] = step_bit[k][p] ? diff[k][p][PW-1:0] : shl[k][p][PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= W; k++) begin
            r_valid_ff[k] <= 1'b0;
         end
      end else begin
         r_valid_ff[0] <= c_valid_ff;
         for (int k = 1; k <= W; k++) begin
            r_valid_ff[k] <= r_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ctrl_ff[0] <= c_ctrl_ff;
      r_den_ff[0]  <= c_den_ff;
      r_neg_ff[0]  <= c_neg_ff;
      r_big_ff[0]  <= init_big;
      for (int p = 0; p < 2; p++) begin
         r_mag_ff[0][p] <= init_mag[p];
         r_rem_ff[0][p] <= init_rem[p];
         r_nlo_ff[0][p] <= init_nlo[p];
         r_quo_ff[0][p] <= '0;
      end
      for (int k = 1; k <= W; k++) begin
         r_ctrl_ff[k] <= r_ctrl_ff[k-1];
         r_den_ff[k]  <= r_den_ff[k-1];
         r_neg_ff[k]  <= r_neg_ff[k-1];
         r_big_ff[k]  <= r_big_ff[k-1];
         for (int p = 0; p < 2; p++) begin
            r_mag_ff[k][p] <= r_mag_ff[k-1][p];
            r_rem_ff[k][p] <= step_rem[k][p];
            r_nlo_ff[k][p] <= r_nlo_ff[k-1][p] << 1;
            r_quo_ff[k][p] <= {r_quo_ff[k-1][p][W-2:0], step_bit[k][p]};
         end
      end
   end

   // output stage: saturate and pick status
   logic                  o_valid_ff;
   logic [W-1:0]          o_re_ff, o_im_ff;
   logic [1:0]            o_st_ff;
   logic [PW-1:0]         fmag [0:1];
   logic [PW-1:0]         negm [0:1];
   logic [W-1:0]          part [0:1];
   logic [1:0]            ovf;
   cau_pkg::status_type   st;
   logic [W-1:0]          re_in, im_in;

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         if (r_ctrl_ff[W].cmd == cau_pkg::CMD_DIV) begin
            fmag[p] = r_big_ff[W][p] ? '1 : PW'(r_quo_ff[W][p]);
         end else begin
            fmag[p] = r_mag_ff[W][p];
         end
         negm[p] = ~fmag[p] + PW'(1);
         if (r_neg_ff[W][p]) begin
            ovf[p]  = fmag[p] > LIM;
            part[p] = ovf[p] ? MINV : negm[p][W-1:0];
         end else begin
            ovf[p]  = fmag[p] >= LIM;
            part[p] = ovf[p] ? MAXV : fmag[p][W-1:0];
         end
      end
      if (r_ctrl_ff[W].cmd == cau_pkg::CMD_DIV && r_ctrl_ff[W].dbz) begin
         st    = cau_pkg::ST_DBZ;
         re_in = '0;
         im_in = '0;
      end else begin
         st    = (ovf != 2'b00) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
         re_in = part[0];
         im_in = part[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= r_valid_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      o_re_ff <= re_in;
      o_im_ff <= im_in;
      o_st_ff <= st;
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_result_real = o_re_ff;
   assign rsp_result_imag = o_im_ff;
   assign rsp_status      = o_st_ff;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex multiply, divide, add and subtract on signed fixed-point operands.
// ----------------------------------------------------------------------------
// path: command register, queue, stages a, b and c, divider rows, output register;
//   every command takes this same path
// throughput: one word per cycle; the divider is a row-per-quotient-bit pipeline
// reset: synchronous, clears the command register valid bit, queue pointers and all
//   stage valid bits; results cannot be stalled, so busy stays low in use
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [DATA_WIDTH-1:0] req_a_real,
   input  logic [DATA_WIDTH-1:0] req_a_imag,
   input  logic [DATA_WIDTH-1:0] req_b_real,
   input  logic [DATA_WIDTH-1:0] req_b_imag,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_result_real,
   output logic [DATA_WIDTH-1:0] rsp_result_imag,
   output logic [1:0]            rsp_status
);

   // queued word: control plus four operands
   localparam int QW = $bits(cau_pkg::ctrl_type) + 4 * DATA_WIDTH;

   cau_pkg::ctrl_type     fe_ctrl, bk_ctrl;
   logic [DATA_WIDTH-1:0] fe_a_real, fe_a_imag, fe_b_real, fe_b_imag;
   logic [DATA_WIDTH-1:0] bk_a_real, bk_a_imag, bk_b_real, bk_b_imag;
   logic                  push, q_full, q_empty;
   logic [QW-1:0]         q_head;

   // front end: registers the command word and decodes divide by zero
   cau_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_cmd    (req_cmd),
      .req_a_real (req_a_real),
      .req_a_imag (req_a_imag),
      .req_b_real (req_b_real),
      .req_b_imag (req_b_imag),
      .q_full     (q_full),
      .push       (push),
      .fe_ctrl    (fe_ctrl),
      .fe_a_real  (fe_a_real),
      .fe_a_imag  (fe_a_imag),
      .fe_b_real  (fe_b_real),
      .fe_b_imag  (fe_b_imag)
   );

   // decoupling queue; the datapath drains it whenever it holds a word
   cau_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({fe_ctrl, fe_a_real, fe_a_imag, fe_b_real, fe_b_imag}),
      .pop       (~q_empty),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   assign {bk_ctrl, bk_a_real, bk_a_imag, bk_b_real, bk_b_imag} = q_head;

   // back end: fixed-latency datapath, never stalls
   cau_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (~q_empty),
      .in_ctrl         (bk_ctrl),
      .in_a_real       (bk_a_real),
      .in_a_imag       (bk_a_imag),
      .in_b_real       (bk_b_real),
      .in_b_imag       (bk_b_imag),
      .rsp_valid       (rsp_valid),
      .rsp_result_real (rsp_result_real),
      .rsp_result_imag (rsp_result_imag),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== hw/rtl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [DATA_WIDTH-1:0] rsp_result_real,
   input logic [DATA_WIDTH-1:0] rsp_result_imag,
   input logic [1:0]            rsp_status
);

   // the datapath never stalls, so the unit never refuses a word
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cau_pkg::ST_DBZ) |->
      (rsp_result_real == '0 && rsp_result_imag == '0))
      else $error("divide by zero with nonzero parts");

endmodule

bind complex_arithmetic_unit cau_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_result_real (rsp_result_real),
   .rsp_result_imag (rsp_result_imag),
   .rsp_status      (rsp_status)
);

// ===== tb/sv/tb_complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking bench for the complex arithmetic unit. Operand words go
// through a queue-fed driver with random gaps. A wide-integer predictor
// computes the expected parts and status of each accepted word. The monitor
// compares every result strobe with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;

   localparam int DW        = 32;
   localparam int FB        = 16;
   localparam int LATENCY   = DW + 6;
   localparam int N_RANDOM  = 1800;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      cau_pkg::cmd_type cmd;
      logic [DW-1:0]    ar;
      logic [DW-1:0]    ai;
      logic [DW-1:0]    br;
      logic [DW-1:0]    bi;
   } operand_type;

   typedef struct {
      logic [DW-1:0]       re;
      logic [DW-1:0]       im;
      cau_pkg::status_type st;
   } result_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [1:0]    req_cmd;
   logic [DW-1:0] req_a_real, req_a_imag, req_b_real, req_b_imag;
   logic          rsp_valid;
   logic [DW-1:0] rsp_result_real, rsp_result_imag;
   logic [1:0]    rsp_status;

   operand_type   pending_q[$];    // words not yet handed to the block
   result_type    expected_q[$];   // predictions waiting for their strobe
   int            errors;
   int            cycles;
   int            gap_left;
   bit            taken;           // word on the request ports was accepted
   int            op_count[4];
   int            dbz_seen, ovf_seen;

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_result_real(rsp_result_real),
      .rsp_result_imag(rsp_result_imag), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // clamp an exact value to the signed data range, flag when clipped
   function automatic logic [DW-1:0] clamp_part(input logic signed [127:0] v,
                                                inout bit clipped);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (DW-1)) - 1;
      lo = -(128'sd1 <<< (DW-1));
      if (v > hi) begin
         clipped = 1'b1;
         return hi[DW-1:0];
      end
      if (v < lo) begin
         clipped = 1'b1;
         return lo[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // exact complex arithmetic in 128-bit signed integers; signed divide in
   // sv truncates toward zero, which matches both the product shift and
   // the quotient rounding of the block
   function automatic result_type complex_result(input operand_type w);
      logic signed [127:0] ar, ai, br, bi, re, im, den;
      result_type r;
      bit clipped;
      ar = 128'(signed'(w.ar));
      ai = 128'(signed'(w.ai));
      br = 128'(signed'(w.br));
      bi = 128'(signed'(w.bi));
      clipped = 1'b0;
      case (w.cmd)
         cau_pkg::CMD_MUL: begin
            re = (ar * br - ai * bi) / (128'sd1 <<< FB);
            im = (ar * bi + ai * br) / (128'sd1 <<< FB);
         end
         cau_pkg::CMD_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.re = '0;
               r.im = '0;
               r.st = cau_pkg::ST_DBZ;
               return r;
            end
            re = ((ar * br + ai * bi) * (128'sd1 <<< FB)) / den;
            im = ((ai * br - ar * bi) * (128'sd1 <<< FB)) / den;
         end
         cau_pkg::CMD_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         default: begin
            re = ar - br;
            im = ai - bi;
         end
      endcase
      r.re = clamp_part(re, clipped);
      r.im = clamp_part(im, clipped);
      r.st = clipped ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
      return r;
   endfunction

   // operand value: full range, small magnitudes, extremes or zero
   function automatic logic [DW-1:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return $urandom;
      if (sel < 7) return DW'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      if (sel == 7) return $urandom_range(0, 1) ? {1'b1, {(DW-1){1'b0}}}
                                                  : {1'b0, {(DW-1){1'b1}}};
      if (sel == 8) return DW'(signed'($urandom_range(0, 2)) - 1);
      return '0;
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return 0;
      if (sel < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 45);
   endfunction

   task automatic add_word(input cau_pkg::cmd_type c, input logic [DW-1:0] ar,
                           input logic [DW-1:0] ai, input logic [DW-1:0] br,
                           input logic [DW-1:0] bi);
      operand_type w;
      w.cmd = c; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
      pending_q.push_back(w);
   endtask

   // driver: request ports change on the falling edge only
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_q.size() > 0) begin
            operand_type w;
            w = pending_q.pop_front();
            start      <= 1'b1;
            req_cmd    <= w.cmd;
            req_a_real <= w.ar;
            req_a_imag <= w.ai;
            req_b_real <= w.br;
            req_b_imag <= w.bi;
            gap_left   <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: sample on the rising edge, predict on accept, check on strobe
   always @(posedge clock) begin
      taken <= !reset && start && !busy;
      if (!reset) begin
         cycles <= cycles + 1;
         if (start && !busy) begin
            operand_type w;
            result_type  r;
            w.cmd = cau_pkg::cmd_type'(req_cmd);
            w.ar = req_a_real; w.ai = req_a_imag;
            w.br = req_b_real; w.bi = req_b_imag;
            r = complex_result(w);
            expected_q.push_back(r);
            op_count[req_cmd]++;
            if (r.st == cau_pkg::ST_DBZ) dbz_seen++;
            if (r.st == cau_pkg::ST_OVF) ovf_seen++;
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               result_type e;
               e = expected_q.pop_front();
               if (rsp_result_real !== e.re) begin
                  $error("result_real: expected %h, got %h", e.re, rsp_result_real);
                  errors++;
               end
               if (rsp_result_imag !== e.im) begin
                  $error("result_imag: expected %h, got %h", e.im, rsp_result_imag);
                  errors++;
               end
               if (rsp_status !== e.st) begin
                  $error("status: expected %0d, got %0d", e.st, rsp_status);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles >= MAX_CYCLE) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [DW-1:0] maxv, minv, one;
      cau_pkg::cmd_type c;
      maxv = {1'b0, {(DW-1){1'b1}}};
      minv = {1'b1, {(DW-1){1'b0}}};
      one  = DW'(1) << FB;
      errors = 0; cycles = 0; gap_left = 0; taken = 1'b0;
      dbz_seen = 0; ovf_seen = 0;
      op_count = '{default: 0};
      reset = 1'b1; start = 1'b0; req_cmd = cau_pkg::CMD_MUL;
      req_a_real = '0; req_a_imag = '0; req_b_real = '0; req_b_imag = '0;

      // directed words: extremes, every command, zero divisor, clipping
      add_word(cau_pkg::CMD_MUL, one, one, one, '0);
      add_word(cau_pkg::CMD_MUL, minv, minv, minv, minv);
      add_word(cau_pkg::CMD_MUL, maxv, maxv, maxv, maxv);
      add_word(cau_pkg::CMD_MUL, minv, maxv, '1, 1);
      add_word(cau_pkg::CMD_MUL, '1, '1, 1, '1);
      add_word(cau_pkg::CMD_DIV, one, one, '0, '0);            // divide by zero
      add_word(cau_pkg::CMD_DIV, '0, '0, '0, '0);              // zero over zero
      add_word(cau_pkg::CMD_DIV, maxv, maxv, 1, '0);           // tiny divisor clips
      add_word(cau_pkg::CMD_DIV, minv, minv, '0, 1);
      add_word(cau_pkg::CMD_DIV, one, '0, one, one);
      add_word(cau_pkg::CMD_DIV, minv, minv, minv, minv);
      add_word(cau_pkg::CMD_DIV, maxv, minv, maxv, maxv);
      add_word(cau_pkg::CMD_DIV, 1, '1, maxv, minv);           // quotient truncates to zero
      add_word(cau_pkg::CMD_ADD, maxv, minv, 1, '1);           // both directions clip
      add_word(cau_pkg::CMD_ADD, minv, maxv, minv, maxv);
      add_word(cau_pkg::CMD_ADD, maxv, minv, minv, maxv);
      add_word(cau_pkg::CMD_SUB, minv, maxv, 1, '1);
      add_word(cau_pkg::CMD_SUB, maxv, minv, maxv, minv);
      add_word(cau_pkg::CMD_SUB, '0, '0, minv, maxv);
      add_word(cau_pkg::CMD_SUB, one, '1, one, '1);

      for (int i = 0; i < N_RANDOM; i++) begin
         c = cau_pkg::cmd_type'($urandom_range(0, 3));
         if (c == cau_pkg::CMD_DIV && $urandom_range(0, 15) == 0)
            add_word(c, pick_operand(), pick_operand(), '0, '0);
         else
            add_word(c, pick_operand(), pick_operand(), pick_operand(),
                     pick_operand());
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || start) @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d mul, %0d div, %0d add, %0d sub words",
               op_count[cau_pkg::CMD_MUL], op_count[cau_pkg::CMD_DIV],
               op_count[cau_pkg::CMD_ADD], op_count[cau_pkg::CMD_SUB]);
      $display("%0d divide-by-zero and %0d saturated results", dbz_seen, ovf_seen);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_queue.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arithmetic_unit.sv
hw/rtl/cau_checker.sv
tb/sv/tb_complex_arithmetic_unit.sv
